>>> rtl/core/bfst_pkg.sv
// Package for the best-fit free space table.
// Sizes, status codes, request codes, FSM states and memory control types.
// No dependencies.
package bfst_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int REQ_W       = 2;
    localparam int STAT_W      = 2;
    localparam int CNT_OUT_W   = 7;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [DATA_W-1:0] INVALID_CODE_RST = 32'hFFFF_FFFF;
    localparam logic [PADDR_W-3:0] REG_INVALID_CODE = '0;

    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

    typedef logic [CNT_W-1:0] t_count;
    typedef logic [IDX_W-1:0] t_index;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] id;
        logic [DATA_W-1:0] space;
    } t_entry;

    typedef struct packed {
        logic   rd_en;
        t_index rd_addr;
        logic   wr_en;
        t_index wr_addr;
        t_entry wr_data;
    } t_mem_ctl;

endpackage

>>> rtl/core/bfst_ifs.sv
// Handshake interfaces for request and response words.
// Depends on bfst_pkg.
interface bfst_req_if;
    logic                        valid;
    logic                        ready;
    logic [bfst_pkg::REQ_W-1:0]  req_type;
    logic [bfst_pkg::DATA_W-1:0] page_id;
    logic [bfst_pkg::DATA_W-1:0] new_space;
    logic [bfst_pkg::DATA_W-1:0] required_space;

    modport source (output valid, req_type, page_id, new_space, required_space,
                    input ready);
    modport sink   (input valid, req_type, page_id, new_space, required_space,
                    output ready);
endinterface

interface bfst_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [bfst_pkg::STAT_W-1:0]    status;
    logic [bfst_pkg::DATA_W-1:0]    found_page;
    logic [bfst_pkg::CNT_OUT_W-1:0] entry_count;

    modport source (output valid, status, found_page, entry_count, input ready);
    modport sink   (input valid, status, found_page, entry_count, output ready);
endinterface

>>> rtl/core/bfst_store.sv
// Entry memory: page id and free space pairs, one write and one read port.
// Read data registered. Depends on bfst_pkg.
module bfst_store (
    input  logic              i_clk,
    input  bfst_pkg::t_mem_ctl i_ctl,
    output bfst_pkg::t_entry   o_rdata
);

    bfst_pkg::t_entry r_mem [bfst_pkg::TABLE_DEPTH];
    bfst_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_ctl.rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/best_fit_free_space_table.sv
// Best-fit free space table, top level.
// Requests are taken one at a time: accept, a read of every stored entry
// through the single read port, a drain step, then write-back and result,
// stalled while a result waits. The result register frees the input side.
// Reset (synchronous, active low) empties the table and restores the invalid
// page code; memory contents are left as they are, no clearing pass.
module best_fit_free_space_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bfst_req_if.sink                     i_req,
    bfst_rsp_if.source                   o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bfst_pkg::PADDR_W-1:0] paddr,
    input  logic [bfst_pkg::PDATA_W-1:0] pwdata,
    output logic [bfst_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    bfst_pkg::t_state r_state, n_state;

    logic [bfst_pkg::DATA_W-1:0] r_invalid_code;

    logic [bfst_pkg::REQ_W-1:0]  r_req_type;
    logic [bfst_pkg::DATA_W-1:0] r_page_id;
    logic [bfst_pkg::DATA_W-1:0] r_new_space;
    logic [bfst_pkg::DATA_W-1:0] r_need;

    bfst_pkg::t_count r_count, n_count;
    bfst_pkg::t_count r_rd_idx, n_rd_idx;
    bfst_pkg::t_count r_chk_idx, n_chk_idx;
    logic             r_chk_v, n_chk_v;

    logic             r_hit, n_hit;
    bfst_pkg::t_index r_slot, n_slot;
    bfst_pkg::t_entry r_last, n_last;
    logic             r_have, n_have;
    logic [bfst_pkg::DATA_W-1:0] r_best_space, n_best_space;
    logic [bfst_pkg::DATA_W-1:0] r_best_id, n_best_id;

    logic                            r_out_valid, n_out_valid;
    bfst_pkg::t_status               r_out_status, n_out_status;
    logic [bfst_pkg::DATA_W-1:0]     r_out_found, n_out_found;
    logic [bfst_pkg::CNT_OUT_W-1:0]  r_out_count, n_out_count;

    bfst_pkg::t_mem_ctl mem_ctl;
    bfst_pkg::t_entry   mem_rdata;
    logic               mem_rd_en;
    logic               mem_wr_en;
    bfst_pkg::t_index   mem_wr_addr;
    bfst_pkg::t_entry   mem_wr_data;

    logic accept;
    logic out_free;
    logic fin_go;
    logic cfg_wr;
    bfst_pkg::t_count last_idx;

    bfst_store u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .o_rdata (mem_rdata)
    );

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite
                  & (paddr[bfst_pkg::PADDR_W-1:2] == bfst_pkg::REG_INVALID_CODE);
    assign prdata = (paddr[bfst_pkg::PADDR_W-1:2] == bfst_pkg::REG_INVALID_CODE)
                  ? r_invalid_code : '0;

    assign out_free = ~r_out_valid | o_rsp.ready;
    assign last_idx = r_count - bfst_pkg::t_count'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bfst_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state = bfst_pkg::S_SCAN;
                end
            end
            bfst_pkg::S_SCAN: begin
                if (r_rd_idx == r_count) begin
                    n_state = bfst_pkg::S_FIN;
                end
            end
            bfst_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = bfst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bfst_pkg::S_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb begin
        i_req.ready = 1'b0;
        mem_rd_en   = 1'b0;
        fin_go      = 1'b0;
        case (r_state)
            bfst_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
            end
            bfst_pkg::S_SCAN: begin
                mem_rd_en = (r_rd_idx != r_count);
            end
            bfst_pkg::S_FIN: begin
                fin_go = out_free;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    assign accept  = i_req.valid & i_req.ready;
    assign mem_ctl = '{rd_en:   mem_rd_en,
                       rd_addr: r_rd_idx[bfst_pkg::IDX_W-1:0],
                       wr_en:   mem_wr_en,
                       wr_addr: mem_wr_addr,
                       wr_data: mem_wr_data};

    // scan and finish datapath
    always_comb begin
        n_rd_idx     = r_rd_idx;
        n_chk_v      = 1'b0;
        n_chk_idx    = r_rd_idx;
        n_hit        = r_hit;
        n_slot       = r_slot;
        n_last       = r_last;
        n_have       = r_have;
        n_best_space = r_best_space;
        n_best_id    = r_best_id;
        n_count      = r_count;
        n_out_valid  = r_out_valid & ~o_rsp.ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = r_slot;
        mem_wr_data  = '{id: r_page_id, space: r_new_space};

        if (accept) begin
            n_rd_idx = '0;
            n_hit    = 1'b0;
            n_have   = 1'b0;
        end

        if (mem_rd_en) begin
            n_rd_idx = r_rd_idx + bfst_pkg::t_count'(1);
            n_chk_v  = 1'b1;
        end

        if (r_chk_v) begin
            if (!r_hit && mem_rdata.id == r_page_id) begin
                n_hit  = 1'b1;
                n_slot = r_chk_idx[bfst_pkg::IDX_W-1:0];
            end
            if (r_chk_idx == last_idx) begin
                n_last = mem_rdata;
            end
            if (mem_rdata.space >= r_need && (!r_have || mem_rdata.space < r_best_space)) begin
                n_have       = 1'b1;
                n_best_space = mem_rdata.space;
                n_best_id    = mem_rdata.id;
            end
        end

        if (fin_go) begin
            n_out_valid  = 1'b1;
            n_out_status = bfst_pkg::ST_OK;
            n_out_found  = r_invalid_code;
            case (r_req_type)
                bfst_pkg::REQ_UPDATE: begin
                    if (r_page_id == r_invalid_code) begin
                        n_out_status = bfst_pkg::ST_INVALID;
                    end else if (r_hit) begin
                        mem_wr_en = 1'b1;
                    end else if (r_count == bfst_pkg::t_count'(bfst_pkg::TABLE_DEPTH)) begin
                        n_out_status = bfst_pkg::ST_FULL;
                    end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = r_count[bfst_pkg::IDX_W-1:0];
                        n_count     = r_count + bfst_pkg::t_count'(1);
                    end
                end
                bfst_pkg::REQ_REMOVE: begin
                    if (r_hit) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = r_last;
                        n_count     = last_idx;
                    end else begin
                        n_out_status = bfst_pkg::ST_NOT_FOUND;
                    end
                end
                bfst_pkg::REQ_FIND: begin
                    if (r_have) begin
                        n_out_found = r_best_id;
                    end
                end
                default: begin
                    n_out_status = bfst_pkg::ST_INVALID;
                end
            endcase
            n_out_count = bfst_pkg::CNT_OUT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= bfst_pkg::S_IDLE;
            r_invalid_code <= bfst_pkg::INVALID_CODE_RST;
            r_count        <= '0;
            r_chk_v        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_chk_v     <= n_chk_v;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_invalid_code <= pwdata[bfst_pkg::DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type  <= i_req.req_type;
            r_page_id   <= i_req.page_id;
            r_new_space <= i_req.new_space;
            r_need      <= i_req.required_space;
        end
        r_rd_idx     <= n_rd_idx;
        r_chk_idx    <= n_chk_idx;
        r_hit        <= n_hit;
        r_slot       <= n_slot;
        r_last       <= n_last;
        r_have       <= n_have;
        r_best_space <= n_best_space;
        r_best_id    <= n_best_id;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_page  = r_out_found;
    assign o_rsp.entry_count = r_out_count;

endmodule
